// File: rtl/core/mbrf_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the request framer.
package mbrf_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  FC_READ    = 8'h03;
    localparam logic [7:0]  FC_COIL    = 8'h05;
    localparam logic [7:0]  COIL_ON_HI = 8'hFF;

    localparam int FRAME_LEN = 8;
    localparam int BODY_LEN  = 6;
    localparam int IDX_W     = 3;

    // Byte positions within the frame.
    localparam logic [IDX_W-1:0] POS_DEV     = 3'd0;
    localparam logic [IDX_W-1:0] POS_FUNC    = 3'd1;
    localparam logic [IDX_W-1:0] POS_ADDR_HI = 3'd2;
    localparam logic [IDX_W-1:0] POS_ADDR_LO = 3'd3;
    localparam logic [IDX_W-1:0] POS_DATA_HI = 3'd4;
    localparam logic [IDX_W-1:0] POS_DATA_LO = 3'd5;
    localparam logic [IDX_W-1:0] POS_CRC_LO  = 3'd6;
    localparam logic [IDX_W-1:0] POS_CRC_HI  = 3'd7;

    typedef enum logic {
        MODE_READ = 1'b0,
        MODE_COIL = 1'b1
    } mode_t;

    typedef struct packed {
        logic [7:0] device_id;
        logic [7:0] func;
        logic [7:0] addr_hi;
        logic [7:0] addr_lo;
        logic [7:0] data_hi;
        logic [7:0] data_lo;
    } body_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/mbrf_front.sv
// Front end: accepts a request transaction and builds the six frame body bytes.
module mbrf_front (
    input  logic                 start,
    input  logic                 full,
    input  logic                 mode,
    input  logic [7:0]           device_id,
    input  logic [15:0]          address,
    input  logic [15:0]          quantity,
    input  logic                 coil_on,
    output logic                 busy,
    output logic                 push,
    output mbrf_pkg::body_t      body
);

    assign busy = full;
    assign push = start && !full;

    always_comb
    begin
        body.device_id = device_id;
        body.addr_hi   = address[15:8];
        body.addr_lo   = address[7:0];
        if (mode == mbrf_pkg::MODE_COIL)
        begin
            body.func    = mbrf_pkg::FC_COIL;
            body.data_hi = coil_on ? mbrf_pkg::COIL_ON_HI : 8'h00;
            body.data_lo = 8'h00;
        end
        else
        begin
            body.func    = mbrf_pkg::FC_READ;
            body.data_hi = quantity[15:8];
            body.data_lo = quantity[7:0];
        end
    end

endmodule

// File: rtl/core/mbrf_fifo.sv
// Short queue of frame bodies between the front end and the serializer.
module mbrf_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mbrf_pkg::body_t      push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 valid,
    output mbrf_pkg::body_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbrf_pkg::body_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue read while empty");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on a lone write");
`endif

endmodule

// File: rtl/core/mbrf_back.sv
// Back end: sends one frame byte per cycle and folds the body bytes into the CRC.
module mbrf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  mbrf_pkg::body_t      in_body,
    output logic                 pop,
    output logic                 strobe,
    output logic [7:0]           frame_byte,
    output logic                 last
);

    logic                          active_reg, active_next;
    logic [mbrf_pkg::IDX_W-1:0]    idx_reg, idx_next;
    mbrf_pkg::body_t               body_reg, body_next;
    logic [15:0]                   crc_reg, crc_next;
    logic                          strobe_reg, strobe_next;
    logic [7:0]                    byte_reg, byte_next;
    logic                          last_reg, last_next;
    logic [7:0]                    cur_byte;
    logic                          at_end;

    assign at_end = (idx_reg == mbrf_pkg::POS_CRC_HI);
    assign pop    = in_valid && (!active_reg || at_end);

    always_comb
    begin
        case (idx_reg)
            mbrf_pkg::POS_DEV:     cur_byte = body_reg.device_id;
            mbrf_pkg::POS_FUNC:    cur_byte = body_reg.func;
            mbrf_pkg::POS_ADDR_HI: cur_byte = body_reg.addr_hi;
            mbrf_pkg::POS_ADDR_LO: cur_byte = body_reg.addr_lo;
            mbrf_pkg::POS_DATA_HI: cur_byte = body_reg.data_hi;
            mbrf_pkg::POS_DATA_LO: cur_byte = body_reg.data_lo;
            mbrf_pkg::POS_CRC_LO:  cur_byte = crc_reg[7:0];
            default:               cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        body_next   = body_reg;
        crc_next    = crc_reg;
        strobe_next = active_reg;
        byte_next   = cur_byte;
        last_next   = active_reg && at_end;
        if (active_reg)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg < mbrf_pkg::POS_CRC_LO)
            begin
                crc_next = mbrf_pkg::crc_update(crc_reg, cur_byte);
            end
            if (at_end)
            begin
                active_next = 1'b0;
            end
        end
        // A waiting body is loaded as the previous frame's last byte goes out.
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = mbrf_pkg::POS_DEV;
            body_next   = in_body;
            crc_next    = mbrf_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg <= body_next;
        crc_reg  <= crc_next;
        byte_reg <= byte_next;
    end

    assign strobe     = strobe_reg;
    assign frame_byte = byte_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> strobe_reg)
        else $error("last marker without a byte strobe");

    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |=> strobe_reg)
        else $error("gap inside a frame");

    a_end_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && at_end) |=> (strobe_reg && last_reg))
        else $error("eighth byte not marked last");
`endif

endmodule

// File: rtl/core/modbus_rtu_request_framer_top.sv
// Top level of the Modbus RTU request framer: front end, body queue and serializer.
//
// Each accepted request (start high while busy is low) produces an 8-byte Modbus RTU
// frame: device id, function code (0x03 read holding registers or 0x05 write single
// coil), address high and low, two data bytes, then the CRC-16/MODBUS low and high
// bytes. Bytes leave one per cycle on frame_byte, each marked by a one-cycle strobe,
// with last set on the eighth byte; the receiver must take every byte as it comes.
// The first byte leaves after the queue, the serializer's body register and its byte
// register. A request holds the serializer until its last byte is out; queued frames
// follow each other with no gap. Up to QUEUE_DEPTH requests wait in a queue ahead of
// the serializer; busy is high while that queue is full.
module modbus_rtu_request_framer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  device_id,
    input  logic [15:0] address,
    input  logic [15:0] quantity,
    input  logic        coil_on,
    output logic        strobe,
    output logic [7:0]  frame_byte,
    output logic        last
);

    logic            push;
    logic            pop;
    logic            full;
    logic            q_valid;
    mbrf_pkg::body_t push_body;
    mbrf_pkg::body_t pop_body;

    mbrf_front u_front (
        .start     (start),
        .full      (full),
        .mode      (mode),
        .device_id (device_id),
        .address   (address),
        .quantity  (quantity),
        .coil_on   (coil_on),
        .busy      (busy),
        .push      (push),
        .body      (push_body)
    );

    mbrf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_body),
        .pop       (pop),
        .full      (full),
        .valid     (q_valid),
        .pop_data  (pop_body)
    );

    mbrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_body    (pop_body),
        .pop        (pop),
        .strobe     (strobe),
        .frame_byte (frame_byte),
        .last       (last)
    );

endmodule
